// ===== hw/rtl/harmonic_additive_synth_core_defines.svh =====
// Assertion macros for the harmonic additive synthesizer.
// Used by the top level; expands to nothing under SYNTHESIS.
`ifndef HARMONIC_ADDITIVE_SYNTH_CORE_DEFINES_SVH
`define HARMONIC_ADDITIVE_SYNTH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HASS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("hass assertion failed");
`define HASS_ASSERT_NR(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("hass assertion failed");
`else
`define HASS_ASSERT(lbl, prop)
`define HASS_ASSERT_NR(lbl, prop)
`endif
`endif

// ===== hw/rtl/hass_pkg.sv =====
// Shared types and constants of the harmonic additive synthesizer.
// No dependencies; imported by hass_div, the top level, the checker and the testbench.
`default_nettype none
package hass_pkg;
	localparam int F0_W   = 18;
	localparam int AMP_W  = 16;
	localparam int WGT_W  = 16;
	localparam int NYQ_W  = 20;
	localparam int STEP_W = 32;
	localparam int ACC_W  = 40;

	localparam int DIV_NW = 35;
	localparam int DIV_DW = 25;
	localparam int DIV_QW = 18;

	localparam logic [1:0] FN_LOAD   = 2'd0;
	localparam logic [1:0] FN_FRAME  = 2'd1;
	localparam logic [1:0] FN_SAMPLE = 2'd2;

	localparam logic CFG_NYQ  = 1'b0;
	localparam logic CFG_STEP = 1'b1;

	localparam logic [NYQ_W-1:0]  NYQ_RST  = 20'd128000;
	localparam logic [STEP_W-1:0] STEP_RST = 32'd1099511628;

	localparam logic [31:0] C1 = 32'd1686629713;
	localparam logic [31:0] C3 = 32'd693598668;
	localparam logic [31:0] C5 = 32'd85569306;
	localparam logic [31:0] C7 = 32'd5026994;
	localparam logic [31:0] C9 = 32'd172272;

	typedef struct packed {
		logic [1:0]       func;
		logic [5:0]       harmonic_index;
		logic [WGT_W-1:0] weight;
		logic [AMP_W-1:0] amplitude;
		logic [F0_W-1:0]  fundamental;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_in_frame;
	} out_beat_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_QW-1:0] quot;
	} div_resp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_F1_RD, ST_F1_ACC, ST_F2_RD, ST_F2_MUL, ST_F2_DS, ST_F2_DW, ST_F_END,
		ST_S_FREQ, ST_R_M1, ST_R_M2, ST_R_DS, ST_R_DW, ST_R_Q, ST_S_INC, ST_S_PH,
		ST_H_RDP, ST_H_RDC, ST_H_AMP, ST_SN_X2, ST_SN_P9, ST_SN_P7, ST_SN_P5, ST_SN_P3,
		ST_SN_P1, ST_SN_S, ST_SN_ACC, ST_OUT
	} st_t;
endpackage
`default_nettype wire

// ===== hw/rtl/hass_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on hass_pkg for the request and response structs.
`default_nettype none
module hass_div import hass_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_resp_t resp
);
	localparam int SW = DIV_DW + DIV_QW - 1;
	localparam int CW = $clog2(DIV_QW);

	logic [DIV_NW-1:0] rem_q;
	logic [SW-1:0]     dsh_q;
	logic [DIV_QW-1:0] quot_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	assign fits = SW'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= SW'(req.den) << (DIV_QW - 1);
		end else if (busy_q) begin
			if (fits) rem_q <= rem_q - DIV_NW'(dsh_q);
			quot_q <= {quot_q[DIV_QW-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign resp = '{busy: busy_q, done: done_q, quot: quot_q};
endmodule
`default_nettype wire

// ===== hw/rtl/harmonic_additive_synth_core.sv =====
// Harmonic additive synthesizer: sequencer, weight and amplitude stores, shared multiplier.
// Depends on hass_pkg, hass_div and harmonic_additive_synth_core_defines.svh.
//
// One beat is taken at a time. A weight load or an unused code is handled in the idle state. A
// frame start makes one pass to sum the kept weights, then per harmonic one multiply and a
// divide; the multiply and the divide are skipped when every kept weight is zero. A sample is
// formed step by step on the single 32x32 multiplier that forms each sine, each product and each
// ramp value (by reciprocal multiplication) in turn; ramp values are formed only during the first
// FRAME_SAMPLES/2 samples of a frame, and a finished sample waits while the previous sample is
// still in the output register. A finished sample waits in the output register while the next
// beat is taken. Sine values are computed, not stored.
`default_nettype none
`include "harmonic_additive_synth_core_defines.svh"
module harmonic_additive_synth_core import hass_pkg::*; #(
	parameter int HARMONICS     = 64,
	parameter int FRAME_SAMPLES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int HIW = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
	localparam int AIW = HIW + 1;
	localparam int PW  = $clog2(FRAME_SAMPLES + 1);
	localparam int M   = FRAME_SAMPLES / 2;
	localparam int ML  = $clog2(M);
	localparam int RK  = F0_W + 2 * ML;
	localparam logic [31:0] RCP = 32'(((64'd1 << RK) + 64'(M - 1)) / 64'(M));
	localparam int FHW = F0_W + $clog2(HARMONICS + 1);
	localparam int TW  = WGT_W + $clog2(HARMONICS + 1);
	localparam logic [HIW-1:0] H_LAST  = HIW'(HARMONICS - 1);
	localparam logic [PW-1:0]  M_POS   = PW'(M);
	localparam logic [PW-1:0]  FS_LAST = PW'(FRAME_SAMPLES - 1);
	localparam logic [PW-1:0]  FS_END  = PW'(FRAME_SAMPLES);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(16384);

	st_t state_q, state_d;

	logic [NYQ_W-1:0]  nyq_q;
	logic [STEP_W-1:0] step_q;

	logic [WGT_W-1:0]     wmem [HARMONICS];
	logic [HARMONICS-1:0] wval_q;
	logic [WGT_W-1:0]     w_rd_q;
	logic                 wv_rd_q;

	logic [AMP_W-1:0]       amem [2*HARMONICS];
	logic [2*HARMONICS-1:0] aval_q;
	logic [AMP_W-1:0]       a_rd_q;
	logic                   av_rd_q;

	logic            bank_q;
	logic [F0_W-1:0] prev_f_q, cur_f_q, f0_q, f_q;
	logic            have_f_q;
	logic [31:0]     phase_q, ph_q;
	logic [PW-1:0]   pos_q;

	logic [HIW-1:0]   h_q;
	logic [AMP_W-1:0] amp_q, prev_a_q, cur_a_q, a_q;
	logic [FHW-1:0]   fh_q;
	logic [TW-1:0]    total_q;
	logic             ramp_f_q;
	logic [31:0]      num_q, x2_q;
	logic             neg_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [63:0]      prod_q;
	logic [31:0]      mul_a, mul_b;

	logic      out_valid_q;
	out_beat_t out_q;

	div_req_t  div_req;
	div_resp_t div_resp;

	logic             in_fire, idx_ok, w_we, a_we, h_last, held, out_load;
	logic [HIW-1:0]   widx;
	logic [AIW-1:0]   a_raddr, a_waddr;
	logic [AMP_W-1:0] a_wdata, a_eff;
	logic [WGT_W-1:0] w_eff, kept;
	logic [14:0]      x, sine_mag;
	logic [31:0]      x30, prod_hi;
	logic [32:0]      s_rnd;
	logic [F0_W-1:0]  ramp_prev, ramp_cur;
	logic signed [ACC_W-1:0] rnd_s, term;

	hass_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .resp(div_resp));

	assign in_fire  = in_valid && in_ready;
	assign idx_ok   = 32'(in_data.harmonic_index) < HARMONICS;
	assign widx     = HIW'(in_data.harmonic_index);
	assign h_last   = h_q == H_LAST;
	assign held     = pos_q >= M_POS;
	assign w_eff    = wv_rd_q ? w_rd_q : '0;
	assign a_eff    = av_rd_q ? a_rd_q : '0;
	assign kept     = (32'(fh_q) >= 32'(nyq_q)) ? '0 : w_eff;
	assign a_raddr  = (state_q == ST_H_RDC) ? {bank_q, h_q} : {~bank_q, h_q};
	assign a_waddr  = {~bank_q, h_q};
	assign x        = ph_q[30] ? (15'd16384 - {1'b0, ph_q[29:16]}) : {1'b0, ph_q[29:16]};
	assign x30      = {1'b0, x, 16'd0};
	assign prod_hi  = prod_q[61:30];
	assign s_rnd    = {1'b0, prod_hi} + 33'd16384;
	assign sine_mag = (s_rnd[32:15] > 18'd32767) ? 15'd32767 : s_rnd[29:15];
	assign ramp_prev = ramp_f_q ? prev_f_q : F0_W'(prev_a_q);
	assign ramp_cur  = ramp_f_q ? cur_f_q : F0_W'(cur_a_q);
	assign term     = ACC_W'(prod_q[30:0]);
	assign rnd_s    = (acc_q + RND) >>> 15;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		div_req  = '0;
		w_we     = 1'b0;
		a_we     = 1'b0;
		a_wdata  = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_data.func)
						FN_LOAD:   w_we = idx_ok;
						FN_FRAME:  state_d = ST_F1_RD;
						FN_SAMPLE: state_d = ST_S_FREQ;
						default: ;
					endcase
				end
			end
			ST_F1_RD:  state_d = ST_F1_ACC;
			ST_F1_ACC: state_d = h_last ? ST_F2_RD : ST_F1_RD;
			ST_F2_RD:  state_d = ST_F2_MUL;
			ST_F2_MUL: begin
				if (total_q == '0) begin
					a_we    = 1'b1;
					state_d = h_last ? ST_F_END : ST_F2_RD;
				end else begin
					mul_a   = 32'(kept);
					mul_b   = 32'(amp_q);
					state_d = ST_F2_DS;
				end
			end
			ST_F2_DS: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'({prod_q[32:0], 1'b0}) + DIV_NW'(total_q);
				div_req.den   = DIV_DW'({total_q, 1'b0});
				state_d       = ST_F2_DW;
			end
			ST_F2_DW: begin
				if (div_resp.done) begin
					a_we    = 1'b1;
					a_wdata = (|div_resp.quot[DIV_QW-1:AMP_W]) ? '1 : div_resp.quot[AMP_W-1:0];
					state_d = h_last ? ST_F_END : ST_F2_RD;
				end
			end
			ST_F_END:  state_d = ST_IDLE;
			ST_S_FREQ: state_d = held ? ST_S_INC : ST_R_M1;
			ST_R_M1: begin
				mul_a   = 32'(ramp_prev);
				mul_b   = 32'(M_POS - pos_q);
				state_d = ST_R_M2;
			end
			ST_R_M2: begin
				mul_a   = 32'(ramp_cur);
				mul_b   = 32'(pos_q);
				state_d = ST_R_DS;
			end
			ST_R_DS: state_d = ST_R_DW;
			ST_R_DW: begin
				mul_a   = num_q;
				mul_b   = RCP;
				state_d = ST_R_Q;
			end
			ST_R_Q: state_d = ramp_f_q ? ST_S_INC : ST_SN_X2;
			ST_S_INC: begin
				mul_a   = 32'(f_q);
				mul_b   = step_q;
				state_d = ST_S_PH;
			end
			ST_S_PH:  state_d = ST_H_RDP;
			ST_H_RDP: state_d = ST_H_RDC;
			ST_H_RDC: state_d = ST_H_AMP;
			ST_H_AMP: state_d = held ? ST_SN_X2 : ST_R_M1;
			ST_SN_X2: begin
				mul_a   = x30;
				mul_b   = x30;
				state_d = ST_SN_P9;
			end
			ST_SN_P9: begin
				mul_a   = C9;
				mul_b   = prod_hi;
				state_d = ST_SN_P7;
			end
			ST_SN_P7: begin
				mul_a   = C7 - prod_hi;
				mul_b   = x2_q;
				state_d = ST_SN_P5;
			end
			ST_SN_P5: begin
				mul_a   = C5 - prod_hi;
				mul_b   = x2_q;
				state_d = ST_SN_P3;
			end
			ST_SN_P3: begin
				mul_a   = C3 - prod_hi;
				mul_b   = x2_q;
				state_d = ST_SN_P1;
			end
			ST_SN_P1: begin
				mul_a   = C1 - prod_hi;
				mul_b   = x30;
				state_d = ST_SN_S;
			end
			ST_SN_S: begin
				mul_a   = 32'(sine_mag);
				mul_b   = 32'(a_q);
				state_d = ST_SN_ACC;
			end
			ST_SN_ACC: state_d = h_last ? ST_OUT : ST_H_RDP;
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nyq_q  <= NYQ_RST;
			step_q <= STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NYQ:  nyq_q  <= cfg_data[NYQ_W-1:0];
				CFG_STEP: step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wval_q      <= '0;
			aval_q      <= '0;
			bank_q      <= 1'b0;
			prev_f_q    <= '0;
			cur_f_q     <= '0;
			have_f_q    <= 1'b0;
			phase_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (w_we) wval_q[widx] <= 1'b1;
			if (a_we) aval_q[a_waddr] <= 1'b1;
			if (state_q == ST_F_END) begin
				bank_q   <= ~bank_q;
				prev_f_q <= have_f_q ? cur_f_q : f0_q;
				cur_f_q  <= f0_q;
				have_f_q <= 1'b1;
				pos_q    <= '0;
			end
			if (state_q == ST_S_PH) phase_q <= phase_q + prod_q[47:16];
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (pos_q < FS_END) pos_q <= pos_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) wmem[widx] <= in_data.weight;
		w_rd_q  <= wmem[h_q];
		wv_rd_q <= wval_q[h_q];
		if (a_we) amem[a_waddr] <= a_wdata;
		a_rd_q  <= amem[a_raddr];
		av_rd_q <= aval_q[a_raddr];
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					amp_q   <= in_data.amplitude;
					f0_q    <= in_data.fundamental;
					fh_q    <= FHW'(in_data.fundamental);
					h_q     <= '0;
					total_q <= '0;
				end
			end
			ST_F1_ACC: begin
				total_q <= total_q + TW'(kept);
				if (h_last) begin
					h_q  <= '0;
					fh_q <= FHW'(f0_q);
				end else begin
					h_q  <= h_q + 1'b1;
					fh_q <= fh_q + FHW'(f0_q);
				end
			end
			ST_F2_MUL: begin
				if (total_q == '0) begin
					h_q  <= h_q + 1'b1;
					fh_q <= fh_q + FHW'(f0_q);
				end
			end
			ST_F2_DW: begin
				if (div_resp.done) begin
					h_q  <= h_q + 1'b1;
					fh_q <= fh_q + FHW'(f0_q);
				end
			end
			ST_S_FREQ: begin
				ramp_f_q <= 1'b1;
				f_q      <= cur_f_q;
			end
			ST_R_M2: num_q <= prod_q[31:0];
			ST_R_DS: num_q <= num_q + prod_q[31:0];
			ST_R_Q: begin
				if (ramp_f_q) f_q <= prod_q[RK +: F0_W];
				else          a_q <= prod_q[RK +: AMP_W];
			end
			ST_S_PH: begin
				ph_q  <= phase_q + prod_q[47:16];
				h_q   <= '0;
				acc_q <= '0;
			end
			ST_H_RDC: prev_a_q <= a_eff;
			ST_H_AMP: begin
				cur_a_q  <= a_eff;
				a_q      <= a_eff;
				ramp_f_q <= 1'b0;
			end
			ST_SN_P9: x2_q <= prod_hi;
			ST_SN_S:  neg_q <= ph_q[31];
			ST_SN_ACC: begin
				acc_q <= neg_q ? (acc_q - term) : (acc_q + term);
				h_q   <= h_q + 1'b1;
				ph_q  <= ph_q + phase_q;
			end
			ST_OUT: begin
				if (out_load) begin
					if (rnd_s > SAT_HI)      out_q.sample <= 16'sh7FFF;
					else if (rnd_s < SAT_LO) out_q.sample <= 16'sh8000;
					else                     out_q.sample <= rnd_s[15:0];
					out_q.last_in_frame <= pos_q == FS_LAST;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`HASS_ASSERT(a_div_start_idle, div_req.start |-> !div_resp.busy)
	`HASS_ASSERT(a_div_done_wait, div_resp.done |-> (state_q == ST_F2_DW))
	`HASS_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
	`HASS_ASSERT_NR(a_rst_quiet, !arst_n |=> !out_valid_q)
endmodule
`default_nettype wire

// ===== verif/harmonic_additive_synth_checker.sv =====
// Scoreboard for the harmonic additive synthesizer: tracks config writes and input beats,
// predicts each sample and compares it against the output channel.
// Depends on hass_pkg.
module harmonic_additive_synth_checker import hass_pkg::*; #(
	parameter int HARMONICS     = 64,
	parameter int FRAME_SAMPLES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_beat_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_beat_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          pending,
	output int          fails
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF = FRAME_SAMPLES / 2;

	logic [NYQ_W-1:0]  nyq;
	logic [STEP_W-1:0] step;
	logic [15:0]       wstore [HARMONICS];
	logic [15:0]       amp_prev [HARMONICS];
	logic [15:0]       amp_cur [HARMONICS];
	logic [F0_W-1:0]   f0_prev, f0_cur;
	logic              f0_seen;
	logic [31:0]       phase;
	int unsigned       pos;
	out_beat_t         sample_q [$];
	int                mism;

	function automatic int sine_q15(logic [15:0] idx);
		logic [63:0] x, x30, x2, p, s, q;
		x = idx[14] ? 64'(16384 - idx[13:0]) : 64'(idx[13:0]);
		x30 = x << 16;
		x2 = (x30 * x30) >> 30;
		p = 64'(C9);
		p = 64'(C7) - ((p * x2) >> 30);
		p = 64'(C5) - ((p * x2) >> 30);
		p = 64'(C3) - ((p * x2) >> 30);
		p = 64'(C1) - ((p * x2) >> 30);
		s = (p * x30) >> 30;
		q = (s + 16384) >> 15;
		if (q > 32767)
			q = 32767;
		return idx[15] ? -int'(q) : int'(q);
	endfunction

	function automatic logic [63:0] ramp(logic [63:0] a, logic [63:0] b, int unsigned at);
		if (at >= HALF)
			return b;
		return (a * (HALF - at) + b * at) / HALF;
	endfunction

	task automatic start_frame(logic [15:0] amp, logic [F0_W-1:0] f0);
		logic [15:0] kept [HARMONICS];
		logic [63:0] total, a;
		total = 0;
		for (int h = 0; h < HARMONICS; h++) begin
			kept[h] = (64'(h + 1) * f0 >= 64'(nyq)) ? 16'd0 : wstore[h];
			total += kept[h];
		end
		for (int h = 0; h < HARMONICS; h++) begin
			a = 0;
			if (total != 0)
				a = (64'(kept[h]) * amp * 2 + total) / (2 * total);
			if (a > 64'hFFFF)
				a = 64'hFFFF;
			amp_prev[h] = amp_cur[h];
			amp_cur[h] = a[15:0];
		end
		f0_prev = f0_seen ? f0_cur : f0;
		f0_cur = f0;
		f0_seen = 1'b1;
		pos = 0;
	endtask

	function automatic out_beat_t next_sample();
		out_beat_t r;
		logic [63:0] f, inc;
		logic [31:0] ph;
		longint acc, v;
		f = ramp(f0_prev, f0_cur, pos);
		inc = (f * step) >> 16;
		phase = phase + inc[31:0];
		acc = 0;
		for (int h = 0; h < HARMONICS; h++) begin
			ph = phase * 32'(h + 1);
			acc += longint'(sine_q15(ph[31:16])) *
				longint'(ramp(amp_prev[h], amp_cur[h], pos));
		end
		v = (acc + 16384) >>> 15;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		r.sample = v[15:0];
		r.last_in_frame = (pos == FRAME_SAMPLES - 1);
		if (pos < FRAME_SAMPLES)
			pos++;
		return r;
	endfunction

	assign pending = sample_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			nyq <= NYQ_RST;
			step <= STEP_RST;
			for (int h = 0; h < HARMONICS; h++) begin
				wstore[h] = 0;
				amp_prev[h] = 0;
				amp_cur[h] = 0;
			end
			f0_prev = 0;
			f0_cur = 0;
			f0_seen = 0;
			phase = 0;
			pos = 0;
			sample_q.delete();
			fails = 0;
			mism = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (sample_q.size() == 0) begin
					fails++;
					if (mism++ < 10)
						$display("unexpected sample %0d last %0b", out_data.sample,
							out_data.last_in_frame);
				end else begin
					want = sample_q.pop_front();
					if (want != out_data) begin
						fails++;
						if (mism++ < 10)
							$display("sample mismatch: exp %0d/%0b got %0d/%0b",
								want.sample, want.last_in_frame,
								out_data.sample, out_data.last_in_frame);
					end
				end
			end
			if (in_valid && in_ready) begin
				case (in_data.func)
					FN_LOAD: begin
						if (in_data.harmonic_index < HARMONICS)
							wstore[in_data.harmonic_index] = in_data.weight;
					end
					FN_FRAME: start_frame(in_data.amplitude, in_data.fundamental);
					FN_SAMPLE: sample_q.push_back(next_sample());
					default: ;
				endcase
			end
			if (cfg_we) begin
				if (cfg_index == CFG_NYQ)
					nyq <= cfg_data[NYQ_W-1:0];
				else
					step <= cfg_data;
			end
		end
	end
endmodule

// ===== verif/harmonic_additive_synth_core_tb.sv =====
// Top of the harmonic additive synthesizer testbench: clock, reset, stimulus and verdict.
// Depends on hass_pkg, harmonic_additive_synth_core and harmonic_additive_synth_checker.
module harmonic_additive_synth_core_tb;
	import hass_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint LIMIT = 40000000;
	localparam int SETTLE = 3000;
	localparam int IBW = $bits(in_beat_t);

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_beat_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_beat_t   out_data;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	int          pending;
	int          fails;
	bit          calm;
	int          stall_len;
	longint      cycles;

	harmonic_additive_synth_core dut (.*);

	harmonic_additive_synth_checker chk (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .cfg_we, .cfg_index, .cfg_data, .pending, .fails
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_len > 0) begin
			stall_len <= stall_len - 1;
		end else begin
			out_ready <= ($urandom_range(0, 2) != 0);
			stall_len <= $urandom_range(1, 8);
		end
	end

	task automatic send(in_beat_t b);
		bit rdy;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_beat_t beat(logic [1:0] fn, logic [5:0] idx, logic [15:0] w,
		logic [15:0] amp, logic [17:0] f0);
		in_beat_t b;
		b = in_beat_t'(IBW'({$urandom, $urandom}));
		b.func = fn;
		b.harmonic_index = idx;
		b.weight = w;
		b.amplitude = amp;
		b.fundamental = f0;
		return b;
	endfunction

	function automatic in_beat_t rand_beat();
		in_beat_t b;
		int sel;
		b = in_beat_t'(IBW'({$urandom, $urandom}));
		sel = $urandom_range(0, 99);
		if (sel < 22)
			b.func = FN_LOAD;
		else if (sel < 32)
			b.func = FN_FRAME;
		else if (sel < 95)
			b.func = FN_SAMPLE;
		else
			b.func = 2'd3;
		case ($urandom_range(0, 3))
			0: b.weight = 16'hFFFF;
			1: b.weight = 0;
			default: ;
		endcase
		if ($urandom_range(0, 2) != 0)
			b.fundamental = F0_W'($urandom_range(0, 4000));
		return b;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send(rand_beat());
	endtask

	initial begin
		in_beat_t b;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = CFG_NYQ;
		cfg_data = 0;
		calm = 0;
		stall_len = 0;
		cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(beat(FN_SAMPLE, 0, 0, 0, 0));
		send(beat(FN_SAMPLE, 0, 0, 0, 0));
		send(beat(2'd3, 0, 16'hFFFF, 16'hFFFF, 18'h3FFFF));
		send(beat(FN_LOAD, 0, 16'hFFFF, 0, 0));
		send(beat(FN_LOAD, 63, 16'd1, 0, 0));
		send(beat(FN_LOAD, 5, 16'd0, 0, 0));
		send(beat(FN_LOAD, 1, 16'd12345, 0, 0));
		send(beat(FN_FRAME, 0, 0, 16'hFFFF, 18'd100));
		repeat (3) send(beat(FN_SAMPLE, 0, 0, 0, 0));
		send(beat(FN_FRAME, 0, 0, 16'd0, 18'h3FFFF));
		repeat (2) send(beat(FN_SAMPLE, 0, 0, 0, 0));
		send(beat(FN_FRAME, 0, 0, 16'd40000, 18'd2000));
		repeat (2) send(beat(FN_SAMPLE, 0, 0, 0, 0));
		send(beat(FN_FRAME, 0, 0, 16'd30000, 18'd0));
		send(beat(FN_SAMPLE, 0, 0, 0, 0));

		send(beat(FN_FRAME, 0, 0, 16'd20000, 18'd1500));
		repeat (260) send(beat(FN_SAMPLE, 0, 0, 0, 0));
		run_random(150);
		drain();

		cfg_write(CFG_NYQ, 32'd1048575);
		cfg_write(CFG_STEP, 32'hFFFFFFFF);
		run_random(180);
		drain();

		cfg_write(CFG_NYQ, 32'd0);
		cfg_write(CFG_STEP, 32'd0);
		run_random(120);
		drain();

		cfg_write(CFG_NYQ, 32'($urandom_range(0, 1048575)));
		cfg_write(CFG_STEP, $urandom);
		run_random(180);
		drain();

		cfg_write(CFG_NYQ, 32'(NYQ_RST));
		cfg_write(CFG_STEP, STEP_RST);
		calm = 1;
		run_random(150);
		drain();

		if (fails == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
